// ----- src/wsb_pkg.sv -----
`default_nettype none

package wsb_pkg;

   // field widths
   localparam int WIDTH_W     = 16;
   localparam int TIME_W      = 16;
   localparam int CMD_W       = 2;
   localparam int CSR_INDEX_W = 1;

   // command codes carried in req_tuser
   localparam logic [CMD_W-1:0] CMD_LEFT  = 2'd0;
   localparam logic [CMD_W-1:0] CMD_RIGHT = 2'd1;
   localparam logic [CMD_W-1:0] CMD_TICK  = 2'd2;

   // register indexes
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH_MAX = 1'd0;
   localparam logic [CSR_INDEX_W-1:0] CSR_WIDTH_MIN = 1'd1;

   // reset values
   localparam logic [WIDTH_W-1:0] WIDTH_MAX_RESET = 16'h3000;
   localparam logic [WIDTH_W-1:0] WIDTH_MIN_RESET = 16'h1000;
   localparam logic [WIDTH_W-1:0] PULSE_RESET     = 16'h2000;

   // pair of wheel pulse widths
   typedef struct packed {
      logic [WIDTH_W-1:0] left;
      logic [WIDTH_W-1:0] right;
   } pulse_pair_type;

   // limits applied by the correction
   typedef struct packed {
      logic [WIDTH_W-1:0] max;
      logic [WIDTH_W-1:0] min;
   } limits_type;

endpackage

`default_nettype wire

// ----- src/wsb_correct.sv -----
`default_nettype none

// Tick correction: raise the width of the wheel with the shorter period by the
// period difference, lower the other (not below 0); over max sets max and min.
module wsb_correct (
   input  wire logic [wsb_pkg::TIME_W-1:0] left_period,
   input  wire logic [wsb_pkg::TIME_W-1:0] right_period,
   input  wire wsb_pkg::pulse_pair_type     pulse_cur,
   input  wire wsb_pkg::limits_type         limits,
   output wsb_pkg::pulse_pair_type          pulse_new,
   output logic                             changed
);

   logic                         raise_left;
   logic [wsb_pkg::WIDTH_W-1:0]  corr;
   logic [wsb_pkg::WIDTH_W-1:0]  up_cur;
   logic [wsb_pkg::WIDTH_W-1:0]  down_cur;
   logic [wsb_pkg::WIDTH_W:0]    sum;
   logic [wsb_pkg::WIDTH_W-1:0]  up_new;
   logic [wsb_pkg::WIDTH_W-1:0]  down_new;

   // pick direction and magnitude
   always_comb begin
      raise_left = right_period > left_period;
      changed    = right_period != left_period;
      corr       = raise_left ? (right_period - left_period) : (left_period - right_period);
      up_cur     = raise_left ? pulse_cur.left  : pulse_cur.right;
      down_cur   = raise_left ? pulse_cur.right : pulse_cur.left;
   end

   // full precision sum, saturating subtract
   always_comb begin
      sum = {1'b0, up_cur} + {1'b0, corr};
      if (sum > {1'b0, limits.max}) begin
         up_new   = limits.max;
         down_new = limits.min;
      end else begin
         up_new   = sum[wsb_pkg::WIDTH_W-1:0];
         down_new = (down_cur > corr) ? (down_cur - corr) : '0;
      end
   end

   // map back to wheels; equal periods keep both widths
   always_comb begin
      if (!changed) begin
         pulse_new = pulse_cur;
      end else if (raise_left) begin
         pulse_new.left  = up_new;
         pulse_new.right = down_new;
      end else begin
         pulse_new.left  = down_new;
         pulse_new.right = up_new;
      end
   end

endmodule

`default_nettype wire

// ----- src/wheel_speed_balancer.sv -----
`default_nettype none

// Channel  Dir  Signals                              Contents
// req      in   req_tvalid/tready/tdata/tuser        tdata: capture_time, tuser: cmd
// rsp      out  rsp_tvalid/tready/tdata/tuser        tdata: left_width, right_width,
//                                                    tuser: widths_changed
// csr      in   csr_valid/ready/index/data           width_max (0), width_min (1)
//
// One word per cycle sustained while rsp is not stalled; rsp_tvalid rises after a word
// passes the input register, then the result register. Period and width state is
// updated as a word moves from the input register into the result register, so the
// next word sees it at once. A stalled rsp holds both stages; req_tready drops only
// when both are full and rsp is stalled. Reset is synchronous and returns widths,
// periods, times and limits to their defaults.
module wheel_speed_balancer (
   input  wire logic                                clock,
   input  wire logic                                reset,
   input  wire logic                                req_tvalid,
   output logic                                     req_tready,
   input  wire logic [wsb_pkg::TIME_W-1:0]          req_tdata,   // [15:0] capture_time
   input  wire logic [wsb_pkg::CMD_W-1:0]           req_tuser,   // [1:0] cmd
   output logic                                     rsp_tvalid,
   input  wire logic                                rsp_tready,
   output logic [2*wsb_pkg::WIDTH_W-1:0]            rsp_tdata,   // [15:0] left_width,
                                                                 // [31:16] right_width
   output logic                                     rsp_tuser,   // [0] widths_changed
   input  wire logic                                csr_valid,
   output logic                                     csr_ready,
   input  wire logic [wsb_pkg::CSR_INDEX_W-1:0]     csr_index,
   input  wire logic [wsb_pkg::WIDTH_W-1:0]         csr_data
);

   // input stage
   logic                          in_valid_ff;
   logic [wsb_pkg::CMD_W-1:0]     in_cmd_ff;
   logic [wsb_pkg::TIME_W-1:0]    in_time_ff;

   // result stage
   logic                          out_valid_ff;
   wsb_pkg::pulse_pair_type       out_pulse_ff;
   logic                          out_changed_ff;

   // block state
   wsb_pkg::limits_type           limits_ff;
   logic [wsb_pkg::TIME_W-1:0]    last_left_ff,  last_left_in;
   logic [wsb_pkg::TIME_W-1:0]    last_right_ff, last_right_in;
   logic [wsb_pkg::TIME_W-1:0]    left_period_ff,  left_period_in;
   logic [wsb_pkg::TIME_W-1:0]    right_period_ff, right_period_in;
   wsb_pkg::pulse_pair_type       pulse_ff, pulse_in;
   logic                          changed_in;

   wsb_pkg::pulse_pair_type       pulse_tick;
   logic                          changed_tick;
   logic                          advance;

   assign advance    = in_valid_ff && (!out_valid_ff || rsp_tready);
   assign req_tready = !in_valid_ff || advance;
   assign csr_ready  = 1'b1;

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tdata  = {out_pulse_ff.right, out_pulse_ff.left};
   assign rsp_tuser  = out_changed_ff;

   wsb_correct u_correct (
      .left_period  (left_period_ff),
      .right_period (right_period_ff),
      .pulse_cur    (pulse_ff),
      .limits       (limits_ff),
      .pulse_new    (pulse_tick),
      .changed      (changed_tick)
   );

   // per command state update
   always_comb begin
      last_left_in    = last_left_ff;
      last_right_in   = last_right_ff;
      left_period_in  = left_period_ff;
      right_period_in = right_period_ff;
      pulse_in        = pulse_ff;
      changed_in      = 1'b0;
      case (in_cmd_ff)
         wsb_pkg::CMD_LEFT: begin
            left_period_in = in_time_ff - last_left_ff;
            last_left_in   = in_time_ff;
         end
         wsb_pkg::CMD_RIGHT: begin
            right_period_in = in_time_ff - last_right_ff;
            last_right_in   = in_time_ff;
         end
         wsb_pkg::CMD_TICK: begin
            pulse_in   = pulse_tick;
            changed_in = changed_tick;
         end
         default: begin
            // unused code: report current widths
         end
      endcase
   end

   // control and state registers
   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff     <= 1'b0;
         out_valid_ff    <= 1'b0;
         limits_ff.max   <= wsb_pkg::WIDTH_MAX_RESET;
         limits_ff.min   <= wsb_pkg::WIDTH_MIN_RESET;
         last_left_ff    <= '0;
         last_right_ff   <= '0;
         left_period_ff  <= '0;
         right_period_ff <= '0;
         pulse_ff.left   <= wsb_pkg::PULSE_RESET;
         pulse_ff.right  <= wsb_pkg::PULSE_RESET;
      end else begin
         if (req_tready) begin
            in_valid_ff <= req_tvalid;
         end
         if (advance) begin
            out_valid_ff    <= 1'b1;
            last_left_ff    <= last_left_in;
            last_right_ff   <= last_right_in;
            left_period_ff  <= left_period_in;
            right_period_ff <= right_period_in;
            pulse_ff        <= pulse_in;
         end else if (rsp_tready) begin
            out_valid_ff <= 1'b0;
         end
         if (csr_valid && csr_ready) begin
            case (csr_index)
               wsb_pkg::CSR_WIDTH_MAX: limits_ff.max <= csr_data;
               wsb_pkg::CSR_WIDTH_MIN: limits_ff.min <= csr_data;
               default: begin
               end
            endcase
         end
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (req_tvalid && req_tready) begin
         in_cmd_ff  <= req_tuser;
         in_time_ff <= req_tdata;
      end
      if (advance) begin
         out_pulse_ff   <= pulse_in;
         out_changed_ff <= changed_in;
      end
   end

endmodule

`default_nettype wire
